// ===== rtl/vbt_pkg.sv =====
// ----------------------------------------------------------------------------
// vbt_pkg
// Shared widths, constants, register index type and sequencer state type of the tracker.
// ----------------------------------------------------------------------------
`default_nettype none
package vbt_pkg;

  localparam int DivW = 40;
  localparam int DivCntW = 6;
  localparam int SqrtCntW = 4;

  localparam logic [16:0] LimitPressure = 17'd26600;
  localparam logic [DivW-1:0] RateNumerator = 40'd15360000;
  localparam logic [DivW-1:0] VentFloor = 40'd26;

  localparam logic [14:0] ThresholdReset = 15'd20;
  localparam logic [19:0] CoefReset = 20'd2422;
  localparam logic [15:0] ArmReset = 16'd50;
  localparam logic [15:0] StepReset = 16'd200;

  typedef enum logic [1:0] {
    REG_THRESHOLD = 2'd0,
    REG_COEF      = 2'd1,
    REG_ARM       = 2'd2,
    REG_STEP      = 2'd3
  } reg_index_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EVAL,
    S_SQRT,
    S_MUL1,
    S_MUL2,
    S_ACC,
    S_DIVV,
    S_DIVR,
    S_MEAN,
    S_OUT
  } state_t;

endpackage
`default_nettype wire

// ===== rtl/vbt_in_if.sv =====
// ----------------------------------------------------------------------------
// vbt_in_if
// Sample channel: valid, ready, pressure sample and elapsed time.
// ----------------------------------------------------------------------------
`default_nettype none
interface vbt_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pressure_raw;
  logic [15:0]        elapsed_ms;

  modport source (output valid, pressure_raw, elapsed_ms, input ready);
  modport sink (input valid, pressure_raw, elapsed_ms, output ready);
endinterface
`default_nettype wire

// ===== rtl/vbt_out_if.sv =====
// ----------------------------------------------------------------------------
// vbt_out_if
// Result channel: valid, ready and the per-sample breath statistics.
// ----------------------------------------------------------------------------
`default_nettype none
interface vbt_out_if;
  logic        valid;
  logic        ready;
  logic        breath_done;
  logic [15:0] breath_volume;
  logic [15:0] minute_vent;
  logic [15:0] minute_vent_mean;
  logic [15:0] breath_rate;
  logic [15:0] breath_rate_mean;
  logic [15:0] expired_volume;
  logic        over_limit;
  logic        in_expiration;

  modport source (output valid, breath_done, breath_volume, minute_vent, minute_vent_mean,
                  breath_rate, breath_rate_mean, expired_volume, over_limit, in_expiration,
                  input ready);
  modport sink (input valid, breath_done, breath_volume, minute_vent, minute_vent_mean,
                breath_rate, breath_rate_mean, expired_volume, over_limit, in_expiration,
                output ready);
endinterface
`default_nettype wire

// ===== rtl/vbt_sqrt.sv =====
// ----------------------------------------------------------------------------
// vbt_sqrt
// Iterative floor square root of a 32-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module vbt_sqrt (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] operand,
  output logic             done,
  output logic [15:0]      root
);
  logic [31:0] rem;
  logic [31:0] res;
  logic [vbt_pkg::SqrtCntW-1:0] cnt;
  logic        busy;
  logic [31:0] bitv;
  logic [31:0] trial;

  assign bitv = 32'd1 << {(~cnt), 1'b0};
  assign trial = res + bitv;
  assign root = res[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= operand;
        res  <= '0;
      end else if (busy) begin
        if (rem >= trial) begin
          rem <= rem - trial;
          res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        cnt <= cnt + 1'b1;
        if (&cnt) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== rtl/vbt_div.sv =====
// ----------------------------------------------------------------------------
// vbt_div
// Restoring divider, one quotient bit per cycle, shared by both breath ratios.
// ----------------------------------------------------------------------------
`default_nettype none
module vbt_div (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  input  wire logic [vbt_pkg::DivW-1:0] numer,
  input  wire logic [vbt_pkg::DivW-1:0] denom,
  output logic                          done,
  output logic [vbt_pkg::DivW-1:0]      quotient
);
  logic [vbt_pkg::DivW-1:0] den;
  logic [vbt_pkg::DivW:0]   rem;
  logic [vbt_pkg::DivW:0]   shifted;
  logic [vbt_pkg::DivCntW-1:0] cnt;
  logic busy;
  logic fits;

  assign shifted = {rem[vbt_pkg::DivW-1:0], quotient[vbt_pkg::DivW-1]};
  assign fits = shifted >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        cnt      <= '0;
        rem      <= '0;
        den      <= denom;
        quotient <= numer;
      end else if (busy) begin
        rem      <= fits ? shifted - {1'b0, den} : shifted;
        quotient <= {quotient[vbt_pkg::DivW-2:0], fits};
        cnt      <= cnt + 1'b1;
        if (cnt == vbt_pkg::DivCntW'(vbt_pkg::DivW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== rtl/venturi_breath_volume_tracker_core.sv =====
// ----------------------------------------------------------------------------
// venturi_breath_volume_tracker_core
// Breath volume, minute ventilation and breath rate from venturi pressure.
//
// Samples enter on the samples channel (pressure in 0.01 Pa, ms elapsed);
// each sample yields exactly one beat on the results channel. Registers are
// written through cfg_write / cfg_index / cfg_data; the user must write them
// only while the block is idle, as the block itself does not enforce this.
// One sample is worked on at a time; samples.ready is high only when idle.
// The sequencer runs one square-root unit and one restoring divider:
//   below threshold, no breath end:  straight to the output
//   at or above threshold:           16-step square root, two multiplies
//   breath end:                      two 40-step divisions, mean update
//   breath end with zero duration:   divisions skipped, mean update
// The next sample can be accepted in the cycle after the result is loaded.
// The result sits in an output register; while the receiver stalls, the
// next sample is still taken and its result waits until the register frees.
// Reset (synchronous) clears all tracking state and restores register
// defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none
module venturi_breath_volume_tracker_core (
  input  wire logic        clk,
  input  wire logic        rst,
  vbt_in_if.sink           samples,
  vbt_out_if.source        results,
  input  wire logic        cfg_write,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [19:0] cfg_data
);
  localparam int W = vbt_pkg::DivW;

  vbt_pkg::state_t state, state_next;

  logic [14:0] press_threshold;
  logic [19:0] flow_coefficient;
  logic [15:0] arm_volume;
  logic [15:0] report_step;

  logic [15:0] smoothed;
  logic [31:0] breath_accum;
  logic [39:0] running_accum;
  logic [39:0] last_report;
  logic        armed;
  logic        expiring;
  logic [31:0] time_since;
  logic [15:0] vent_mean;
  logic [15:0] rate_mean;
  logic [15:0] held_expired;

  logic [15:0] ms;
  logic        over;
  logic        done_flag;
  logic [31:0] dur;
  logic [15:0] bvol;
  logic [15:0] vent;
  logic [15:0] rate;
  logic        vent_small;
  logic [35:0] prod1;
  logic [51:0] prod2;

  logic signed [17:0] psum;
  logic signed [16:0] sm;
  logic [32:0] tsum;
  logic        hot;
  logic        accept;
  logic [39:0] diff;
  logic [43:0] inc;
  logic [44:0] bsum;
  logic [37:0] ba60;

  logic        sq_start, sq_done;
  logic [15:0] sq_root;
  logic        dv_start, dv_done;
  logic [W-1:0] dv_numer, dv_denom, dv_quo;

  logic [17:0] vm_sum, rm_sum;
  logic [15:0] vm_new, rm_new;

  assign accept = samples.valid && samples.ready;
  assign samples.ready = (state == vbt_pkg::S_IDLE);

  assign psum = $signed({2'b00, smoothed}) + 18'(samples.pressure_raw);
  assign sm   = psum[17:1];
  assign tsum = {1'b0, time_since} + {17'd0, samples.elapsed_ms};
  assign hot  = smoothed >= {1'b0, press_threshold};
  assign diff = running_accum - last_report;
  assign inc  = prod2[51:8];
  assign bsum = {13'd0, breath_accum} + {1'b0, inc};
  assign ba60 = ({6'd0, breath_accum} << 6) - ({6'd0, breath_accum} << 2);

  assign vm_sum = {2'b00, vent_mean} + {1'b0, vent_mean, 1'b0} + {2'b00, vent};
  assign rm_sum = {2'b00, rate_mean} + {1'b0, rate_mean, 1'b0} + {2'b00, rate};
  assign vm_new = (vm_sum[17:10] == 8'd0) ? 16'd0 : vm_sum[17:2];
  assign rm_new = (rm_sum[17:10] == 8'd0) ? 16'd0 : rm_sum[17:2];

  vbt_sqrt u_sqrt (
    .clk     (clk),
    .rst     (rst),
    .start   (sq_start),
    .operand ({smoothed, 16'd0}),
    .done    (sq_done),
    .root    (sq_root)
  );

  vbt_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (dv_start),
    .numer    (dv_numer),
    .denom    (dv_denom),
    .done     (dv_done),
    .quotient (dv_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      press_threshold  <= vbt_pkg::ThresholdReset;
      flow_coefficient <= vbt_pkg::CoefReset;
      arm_volume       <= vbt_pkg::ArmReset;
      report_step      <= vbt_pkg::StepReset;
    end else if (cfg_write) begin
      unique case (vbt_pkg::reg_index_t'(cfg_index))
        vbt_pkg::REG_THRESHOLD: press_threshold  <= cfg_data[14:0];
        vbt_pkg::REG_COEF:      flow_coefficient <= cfg_data;
        vbt_pkg::REG_ARM:       arm_volume       <= cfg_data[15:0];
        vbt_pkg::REG_STEP:      report_step      <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= vbt_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    sq_start   = 1'b0;
    dv_start   = 1'b0;
    dv_numer   = {2'b00, ba60};
    dv_denom   = {time_since, 8'd0};
    unique case (state)
      vbt_pkg::S_IDLE: if (accept) state_next = vbt_pkg::S_EVAL;
      vbt_pkg::S_EVAL: begin
        if (hot) begin
          sq_start   = 1'b1;
          state_next = vbt_pkg::S_SQRT;
        end else if (armed) begin
          if (time_since == 32'd0) begin
            state_next = vbt_pkg::S_MEAN;
          end else begin
            dv_start   = 1'b1;
            state_next = vbt_pkg::S_DIVV;
          end
        end else begin
          state_next = vbt_pkg::S_OUT;
        end
      end
      vbt_pkg::S_SQRT: if (sq_done) state_next = vbt_pkg::S_MUL1;
      vbt_pkg::S_MUL1: state_next = vbt_pkg::S_MUL2;
      vbt_pkg::S_MUL2: state_next = vbt_pkg::S_ACC;
      vbt_pkg::S_ACC:  state_next = vbt_pkg::S_OUT;
      vbt_pkg::S_DIVV: begin
        dv_numer = vbt_pkg::RateNumerator;
        dv_denom = {8'd0, dur};
        if (dv_done) begin
          dv_start   = 1'b1;
          state_next = vbt_pkg::S_DIVR;
        end
      end
      vbt_pkg::S_DIVR: if (dv_done) state_next = vbt_pkg::S_MEAN;
      vbt_pkg::S_MEAN: state_next = vbt_pkg::S_OUT;
      vbt_pkg::S_OUT:  if (!results.valid || results.ready) state_next = vbt_pkg::S_IDLE;
      default: state_next = vbt_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      smoothed      <= '0;
      breath_accum  <= '0;
      running_accum <= '0;
      last_report   <= '0;
      armed         <= 1'b0;
      expiring      <= 1'b0;
      time_since    <= '0;
      vent_mean     <= '0;
      rate_mean     <= '0;
      held_expired  <= '0;
    end else begin
      unique case (state)
        vbt_pkg::S_IDLE: begin
          if (accept) begin
            smoothed   <= sm[16] ? 16'd0 : sm[15:0];
            time_since <= tsum[32] ? 32'hFFFF_FFFF : tsum[31:0];
            ms         <= samples.elapsed_ms;
            over       <= sm > $signed(vbt_pkg::LimitPressure);
            done_flag  <= 1'b0;
            bvol       <= '0;
            vent       <= '0;
            rate       <= '0;
          end
        end
        vbt_pkg::S_EVAL: begin
          if (hot) begin
            expiring <= 1'b1;
            if (breath_accum > {arm_volume, 16'd0}) armed <= 1'b1;
          end else begin
            if (diff > {8'd0, report_step, 16'd0}) begin
              held_expired <= (diff[39:32] != 8'd0) ? 16'hFFFF : diff[31:16];
              last_report  <= running_accum;
            end
            if (armed) begin
              done_flag    <= 1'b1;
              armed        <= 1'b0;
              expiring     <= 1'b0;
              time_since   <= '0;
              dur          <= time_since;
              bvol         <= (breath_accum[31:16] == 16'hFFFF) ? 16'hFFFF
                              : breath_accum[31:16];
              breath_accum <= '0;
              vent         <= 16'hFFFF;
              rate         <= 16'hFFFF;
            end
          end
        end
        vbt_pkg::S_MUL1: prod1 <= flow_coefficient * sq_root;
        vbt_pkg::S_MUL2: prod2 <= prod1 * ms;
        vbt_pkg::S_ACC: begin
          breath_accum  <= (bsum[44:32] != 13'd0) ? 32'hFFFF_FFFF : bsum[31:0];
          running_accum <= running_accum + inc[39:0];
        end
        vbt_pkg::S_DIVV: begin
          if (dv_done) begin
            vent       <= (dv_quo[39:16] != 24'd0) ? 16'hFFFF : dv_quo[15:0];
            vent_small <= dv_quo < vbt_pkg::VentFloor;
          end
        end
        vbt_pkg::S_DIVR: begin
          if (dv_done) begin
            rate <= vent_small ? 16'd0
                    : ((dv_quo[39:16] != 24'd0) ? 16'hFFFF : dv_quo[15:0]);
          end
        end
        vbt_pkg::S_MEAN: begin
          vent_mean <= vm_new;
          rate_mean <= rm_new;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (state == vbt_pkg::S_OUT && (!results.valid || results.ready)) begin
      results.valid            <= 1'b1;
      results.breath_done      <= done_flag;
      results.breath_volume    <= bvol;
      results.minute_vent      <= vent;
      results.minute_vent_mean <= vent_mean;
      results.breath_rate      <= rate;
      results.breath_rate_mean <= rate_mean;
      results.expired_volume   <= held_expired;
      results.over_limit       <= over;
      results.in_expiration    <= hot;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  a_armed_expiring: assert property (@(posedge clk) disable iff (rst) armed |-> expiring)
    else $error("armed without expiring");
  a_done_not_hot: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.breath_done |-> !results.in_expiration)
    else $error("breath end flagged at or above threshold");
  a_idle_stats_zero: assert property (@(posedge clk) disable iff (rst)
    results.valid && !results.breath_done |->
      results.breath_volume == 16'd0 && results.minute_vent == 16'd0 &&
      results.breath_rate == 16'd0)
    else $error("breath stats nonzero without breath end");
  a_rate_floor: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.breath_rate != 16'd0 |-> results.minute_vent >= 16'd26)
    else $error("breath rate shown below ventilation floor");
endmodule
`default_nettype wire
